// ----- hdl/tts_pkg.sv -----
package tts_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);

  localparam int unsigned CoordW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned NormW  = 17;
  localparam int unsigned SliceW = 16;
  localparam int unsigned IdxW   = 48;  // slice index and boundary product range
  localparam int unsigned DivW   = 64;
  localparam int unsigned DvsW   = 32;
  localparam int unsigned MulW   = 33;
  localparam int unsigned CiW    = 2;
  localparam int unsigned NumCoord = 3;

  localparam logic [NormW-1:0] NormOne = NormW'(65536);

  // configuration map
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;
  localparam logic [1:0] RegMaxTime    = 2'd0;
  localparam logic [1:0] RegSliceCount = 2'd1;
  localparam logic [1:0] RegOffsetY    = 2'd2;

  localparam logic [TimeW-1:0]  MaxTimeRst    = TimeW'(256);
  localparam logic [SliceW-1:0] SliceCountRst = SliceW'(2000);
  localparam logic [CoordW-1:0] OffsetYRst    = '0;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [31:0]        start_time;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [31:0]        end_time;
  } track_t;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic [16:0]        seg_start_norm_time;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
    logic [16:0]        seg_end_norm_time;
    logic               last;
    logic               overflow;
  } segment_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_TS_S,
    OP_MUL_TE_S,
    OP_DIV_PROD_M,
    OP_DIV_PROD_S,
    OP_SET_SC,
    OP_SET_EC,
    OP_DIV_NORM_T,
    OP_SET_START,
    OP_END_EXACT,
    OP_SET_SPAN,
    OP_MUL_NB_LO,
    OP_MUL_NB_HI,
    OP_SET_BEND,
    OP_SET_NB,
    OP_SET_T,
    OP_END_P0,
    OP_DIV_LAM,
    OP_SET_LAM,
    OP_MUL_C,
    OP_SET_C,
    OP_SET_END_NT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic div_done;
    logic reversed;
    logic sc_eq_ec;
    logic past_span;
    logic t_le_ts;
    logic ci_last;
    logic last_seg;
  } status_t;

endpackage

// ----- hdl/tts_div.sv -----
module tts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tts_pkg::DivW-1:0]   dividend_i,
  input  logic [tts_pkg::DvsW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [tts_pkg::DivW-1:0]   quot_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [$clog2(tts_pkg::DivW)-1:0] cnt_q, cnt_d;
  logic [tts_pkg::DvsW:0]           rem_q, rem_d;
  logic [tts_pkg::DivW-1:0]         quo_q, quo_d;
  logic [tts_pkg::DvsW-1:0]         dvs_q, dvs_d;
  logic [tts_pkg::DvsW:0]           rem_sh;
  logic                             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q[tts_pkg::DvsW-1:0], quo_q[tts_pkg::DivW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[tts_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hdl/tts_datapath.sv -----
module tts_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tts_pkg::op_e                 op_i,
  input  tts_pkg::track_t              in_data_i,
  input  logic [tts_pkg::TimeW-1:0]    max_time_i,
  input  logic [tts_pkg::SliceW-1:0]   slice_count_i,
  input  logic [tts_pkg::CoordW-1:0]   offset_y_i,
  output tts_pkg::status_t             status_o,
  output tts_pkg::segment_t            out_data_o
);

  tts_pkg::track_t                trk_q;
  logic [tts_pkg::TimeW-1:0]      t_q;
  logic [tts_pkg::IdxW-1:0]       sc_q, ec_q, span_q, nb_q;
  logic [2*tts_pkg::MulW-1:0]     prod_q;
  logic [tts_pkg::MulW-1:0]       lam_q;
  logic [tts_pkg::CiW-1:0]        ci_q;
  logic [tts_pkg::SegCntW-1:0]    j_q, nseg_q;
  logic                           ovf_q, multi_q;
  logic [tts_pkg::CoordW-1:0]     st_c_q [tts_pkg::NumCoord];
  logic [tts_pkg::CoordW-1:0]     en_c_q [tts_pkg::NumCoord];
  logic [tts_pkg::NormW-1:0]      st_nt_q, en_nt_q;
  tts_pkg::segment_t              out_q;

  logic [tts_pkg::TimeW-1:0]      m_eff;
  logic [tts_pkg::SliceW-1:0]     s_eff;
  logic [tts_pkg::CoordW-1:0]     p0 [tts_pkg::NumCoord];
  logic [tts_pkg::CoordW-1:0]     p1 [tts_pkg::NumCoord];
  logic [tts_pkg::MulW-1:0]       mul_a, mul_b;
  logic [2*tts_pkg::MulW-1:0]     mul_res;
  logic                           div_start, div_done;
  logic [tts_pkg::DivW-1:0]       div_dvd, quot;
  logic [tts_pkg::DvsW-1:0]       div_dvs;
  logic [tts_pkg::TimeW-1:0]      dt, den, num;
  logic [tts_pkg::MulW-1:0]       a33, b33, d33, mag, q33, c33;
  logic                           neg;
  logic [tts_pkg::NormW-1:0]      nt_sat;
  logic [tts_pkg::IdxW:0]         total;
  logic                           bend_extra, tot_ovf;
  logic                           seg_last;

  assign m_eff = (max_time_i == '0) ? tts_pkg::TimeW'(1) : max_time_i;
  assign s_eff = (slice_count_i == '0) ? tts_pkg::SliceW'(1) : slice_count_i;

  assign p0[0] = trk_q.start_x;
  assign p0[1] = trk_q.start_y;
  assign p0[2] = trk_q.start_z;
  assign p1[0] = trk_q.end_x;
  assign p1[1] = trk_q.end_y;
  assign p1[2] = trk_q.end_z;

  // interpolation of the selected coordinate
  always_comb begin
    a33 = {p0[ci_q][tts_pkg::CoordW-1], p0[ci_q]};
    b33 = {p1[ci_q][tts_pkg::CoordW-1], p1[ci_q]};
    d33 = b33 - a33;
    neg = d33[tts_pkg::MulW-1];
    mag = neg ? (~d33 + 1'b1) : d33;
    q33 = prod_q[2*tts_pkg::MulW-2:tts_pkg::TimeW];
    c33 = neg ? (a33 - q33) : (a33 + q33);
  end

  always_comb begin
    dt  = t_q - trk_q.start_time;
    den = trk_q.end_time - trk_q.start_time;
    num = (dt > den) ? den : dt;
  end

  assign nt_sat = (quot > tts_pkg::DivW'(tts_pkg::NormOne)) ? tts_pkg::NormOne
                                                            : quot[tts_pkg::NormW-1:0];

  always_comb begin
    bend_extra = quot < tts_pkg::DivW'(trk_q.end_time);
    total      = {1'b0, span_q} + (tts_pkg::IdxW+1)'(bend_extra);
    tot_ovf    = total > (tts_pkg::IdxW+1)'(tts_pkg::MaxSegments);
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op_i)
      tts_pkg::OP_MUL_TS_S: begin
        mul_a = tts_pkg::MulW'(trk_q.start_time);
        mul_b = tts_pkg::MulW'(s_eff);
      end
      tts_pkg::OP_MUL_TE_S: begin
        mul_a = tts_pkg::MulW'(trk_q.end_time);
        mul_b = tts_pkg::MulW'(s_eff);
      end
      tts_pkg::OP_MUL_NB_LO: begin
        mul_a = tts_pkg::MulW'(nb_q[31:0]);
        mul_b = tts_pkg::MulW'(m_eff);
      end
      tts_pkg::OP_MUL_NB_HI: begin
        mul_a = tts_pkg::MulW'(nb_q[tts_pkg::IdxW-1:32]);
        mul_b = tts_pkg::MulW'(m_eff);
      end
      tts_pkg::OP_MUL_C: begin
        mul_a = mag;
        mul_b = lam_q;
      end
      default: ;
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod_q[tts_pkg::DivW-1:0];
    div_dvs   = m_eff;
    unique case (op_i)
      tts_pkg::OP_DIV_PROD_M: div_start = 1'b1;
      tts_pkg::OP_DIV_PROD_S: begin
        div_start = 1'b1;
        div_dvs   = tts_pkg::DvsW'(s_eff);
      end
      tts_pkg::OP_DIV_NORM_T: begin
        div_start = 1'b1;
        div_dvd   = {16'b0, t_q, 16'b0};
      end
      tts_pkg::OP_DIV_LAM: begin
        div_start = 1'b1;
        div_dvd   = {num, 32'b0};
        div_dvs   = den;
      end
      default: ;
    endcase
  end

  tts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign seg_last = (j_q + 1'b1) == nseg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q     <= '0;
      ci_q    <= '0;
      multi_q <= 1'b0;
    end else begin
      unique case (op_i)
        tts_pkg::OP_LOAD:     multi_q <= 1'b0;
        tts_pkg::OP_SET_SPAN: begin
          multi_q <= 1'b1;
          j_q     <= '0;
        end
        tts_pkg::OP_SET_LAM:  ci_q <= '0;
        tts_pkg::OP_SET_C:    ci_q <= ci_q + 1'b1;
        tts_pkg::OP_EMIT:     j_q  <= j_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      tts_pkg::OP_LOAD: begin
        trk_q <= in_data_i;
        t_q   <= in_data_i.start_time;
      end
      tts_pkg::OP_MUL_TS_S, tts_pkg::OP_MUL_TE_S, tts_pkg::OP_MUL_NB_LO,
      tts_pkg::OP_MUL_C: prod_q <= mul_res;
      tts_pkg::OP_MUL_NB_HI: prod_q <= prod_q + (mul_res << 32);
      tts_pkg::OP_SET_SC: sc_q <= quot[tts_pkg::IdxW-1:0];
      tts_pkg::OP_SET_EC: ec_q <= quot[tts_pkg::IdxW-1:0];
      tts_pkg::OP_SET_START: begin
        for (int i = 0; i < tts_pkg::NumCoord; i++) st_c_q[i] <= p0[i];
        st_nt_q <= nt_sat;
      end
      tts_pkg::OP_END_EXACT: begin
        for (int i = 0; i < tts_pkg::NumCoord; i++) en_c_q[i] <= p1[i];
        t_q <= trk_q.end_time;
      end
      tts_pkg::OP_END_P0: begin
        for (int i = 0; i < tts_pkg::NumCoord; i++) en_c_q[i] <= p0[i];
      end
      tts_pkg::OP_SET_SPAN: begin
        span_q <= ec_q - sc_q;
        nb_q   <= ec_q;
      end
      tts_pkg::OP_SET_BEND: begin
        ovf_q  <= tot_ovf;
        nseg_q <= tot_ovf ? tts_pkg::SegCntW'(tts_pkg::MaxSegments)
                          : total[tts_pkg::SegCntW-1:0];
      end
      tts_pkg::OP_SET_NB:  nb_q  <= sc_q + tts_pkg::IdxW'(j_q) + tts_pkg::IdxW'(1);
      tts_pkg::OP_SET_T:   t_q   <= quot[tts_pkg::TimeW-1:0];
      tts_pkg::OP_SET_LAM: lam_q <= quot[tts_pkg::MulW-1:0];
      tts_pkg::OP_SET_C:   en_c_q[ci_q] <= c33[tts_pkg::CoordW-1:0];
      tts_pkg::OP_SET_END_NT: en_nt_q <= nt_sat;
      tts_pkg::OP_EMIT: begin
        out_q.seg_start_x         <= st_c_q[0];
        out_q.seg_start_y         <= st_c_q[1] - offset_y_i;
        out_q.seg_start_z         <= st_c_q[2];
        out_q.seg_start_norm_time <= st_nt_q;
        out_q.seg_end_x           <= en_c_q[0];
        out_q.seg_end_y           <= en_c_q[1] - offset_y_i;
        out_q.seg_end_z           <= en_c_q[2];
        out_q.seg_end_norm_time   <= en_nt_q;
        out_q.last                <= !multi_q || seg_last;
        out_q.overflow            <= multi_q && ovf_q;
        for (int i = 0; i < tts_pkg::NumCoord; i++) st_c_q[i] <= en_c_q[i];
        st_nt_q <= en_nt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.div_done  = div_done;
    status_o.reversed  = trk_q.end_time < trk_q.start_time;
    status_o.sc_eq_ec  = sc_q == ec_q;
    status_o.past_span = span_q < (tts_pkg::IdxW'(j_q) + tts_pkg::IdxW'(1));
    status_o.t_le_ts   = t_q <= trk_q.start_time;
    status_o.ci_last   = ci_q == tts_pkg::CiW'(tts_pkg::NumCoord - 1);
    status_o.last_seg  = !multi_q || seg_last;
  end

  assign out_data_o = out_q;

endmodule

// ----- hdl/tts_ctrl.sv -----
module tts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tts_pkg::status_t  status_i,
  output tts_pkg::op_e      op_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SC_MUL, ST_SC_DIV, ST_SC_WAIT, ST_EC_MUL, ST_EC_DIV, ST_EC_WAIT,
    ST_NTS_DIV, ST_NTS_WAIT, ST_CLASS, ST_BE_LO, ST_BE_HI, ST_BE_DIV, ST_BE_WAIT,
    ST_SEG, ST_B_LO, ST_B_HI, ST_B_DIV, ST_B_WAIT, ST_TCHK, ST_LAM_WAIT,
    ST_C_MUL, ST_C_SET, ST_NT_DIV, ST_NT_WAIT, ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    op_o    = tts_pkg::OP_NONE;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        op_o = tts_pkg::OP_LOAD;  state_d = ST_SC_MUL;
      end
      ST_SC_MUL: begin op_o = tts_pkg::OP_MUL_TS_S;   state_d = ST_SC_DIV; end
      ST_SC_DIV: begin op_o = tts_pkg::OP_DIV_PROD_M; state_d = ST_SC_WAIT; end
      ST_SC_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_SC; state_d = ST_EC_MUL;
      end
      ST_EC_MUL: begin op_o = tts_pkg::OP_MUL_TE_S;   state_d = ST_EC_DIV; end
      ST_EC_DIV: begin op_o = tts_pkg::OP_DIV_PROD_M; state_d = ST_EC_WAIT; end
      ST_EC_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_EC; state_d = ST_NTS_DIV;
      end
      ST_NTS_DIV: begin op_o = tts_pkg::OP_DIV_NORM_T; state_d = ST_NTS_WAIT; end
      ST_NTS_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_START; state_d = ST_CLASS;
      end
      ST_CLASS: begin
        if (status_i.reversed || status_i.sc_eq_ec) begin
          op_o = tts_pkg::OP_END_EXACT; state_d = ST_NT_DIV;
        end else begin
          op_o = tts_pkg::OP_SET_SPAN;  state_d = ST_BE_LO;
        end
      end
      ST_BE_LO:  begin op_o = tts_pkg::OP_MUL_NB_LO;  state_d = ST_BE_HI; end
      ST_BE_HI:  begin op_o = tts_pkg::OP_MUL_NB_HI;  state_d = ST_BE_DIV; end
      ST_BE_DIV: begin op_o = tts_pkg::OP_DIV_PROD_S; state_d = ST_BE_WAIT; end
      ST_BE_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_BEND; state_d = ST_SEG;
      end
      ST_SEG: begin
        if (status_i.past_span) begin
          op_o = tts_pkg::OP_END_EXACT; state_d = ST_NT_DIV;
        end else begin
          op_o = tts_pkg::OP_SET_NB;    state_d = ST_B_LO;
        end
      end
      ST_B_LO:  begin op_o = tts_pkg::OP_MUL_NB_LO;  state_d = ST_B_HI; end
      ST_B_HI:  begin op_o = tts_pkg::OP_MUL_NB_HI;  state_d = ST_B_DIV; end
      ST_B_DIV: begin op_o = tts_pkg::OP_DIV_PROD_S; state_d = ST_B_WAIT; end
      ST_B_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_T; state_d = ST_TCHK;
      end
      ST_TCHK: begin
        if (status_i.t_le_ts) begin
          op_o = tts_pkg::OP_END_P0;  state_d = ST_NT_DIV;
        end else begin
          op_o = tts_pkg::OP_DIV_LAM; state_d = ST_LAM_WAIT;
        end
      end
      ST_LAM_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_LAM; state_d = ST_C_MUL;
      end
      ST_C_MUL: begin op_o = tts_pkg::OP_MUL_C; state_d = ST_C_SET; end
      ST_C_SET: begin
        op_o    = tts_pkg::OP_SET_C;
        state_d = status_i.ci_last ? ST_NT_DIV : ST_C_MUL;
      end
      ST_NT_DIV: begin op_o = tts_pkg::OP_DIV_NORM_T; state_d = ST_NT_WAIT; end
      ST_NT_WAIT: if (status_i.div_done) begin
        op_o = tts_pkg::OP_SET_END_NT; state_d = ST_EMIT;
      end
      ST_EMIT: if (slot_free) begin
        op_o    = tts_pkg::OP_EMIT;
        state_d = status_i.last_seg ? ST_IDLE : ST_SEG;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_EMIT && slot_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/track_time_slice_splitter_core.sv -----
// Track time-slice splitter. One input transfer carries a track (start and end
// point in Q16.16, start and end time in Q24.8); the block cuts it at every
// slice boundary k*max_time/slice_count that it crosses and sends one output
// transfer per piece, endpoints interpolated linearly by time, y shifted down by
// offset_y, times normalized by max_time to Q1.16. A track inside one slice, or
// one running backward in time, comes out whole. At most 64 pieces leave per
// track; when more were needed every piece carries overflow and the 64th
// carries last. Work is done by one sequencer over a shared 64-bit
// restoring divider (one quotient bit a cycle) and one 33x33 multiplier.
// For each piece ending on a slice boundary, the boundary time, the
// interpolation weight and the normalized time each take one division; a
// piece may wait for the output register. One track is in work at a time;
// the next input transfer is taken as soon as the last piece sits in the
// output register, even while it waits there.
module track_time_slice_splitter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tts_pkg::track_t             in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tts_pkg::segment_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tts_pkg::AddrW-1:0]   paddr,
  input  logic [tts_pkg::DataW-1:0]   pwdata,
  output logic [tts_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic [tts_pkg::TimeW-1:0]  max_time_q;
  logic [tts_pkg::SliceW-1:0] slice_count_q;
  logic [tts_pkg::CoordW-1:0] offset_y_q;
  logic [1:0]                 reg_idx;
  tts_pkg::op_e               op;
  tts_pkg::status_t           status;

  // Register file: word addressed, writes land on the access phase.
  assign reg_idx = paddr[tts_pkg::AddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_time_q    <= tts_pkg::MaxTimeRst;
      slice_count_q <= tts_pkg::SliceCountRst;
      offset_y_q    <= tts_pkg::OffsetYRst;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        tts_pkg::RegMaxTime:    max_time_q    <= pwdata;
        tts_pkg::RegSliceCount: slice_count_q <= pwdata[tts_pkg::SliceW-1:0];
        tts_pkg::RegOffsetY:    offset_y_q    <= pwdata;
        default: ;  // unmapped address, drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tts_pkg::RegMaxTime:    prdata = max_time_q;
      tts_pkg::RegSliceCount: prdata = tts_pkg::DataW'(slice_count_q);
      tts_pkg::RegOffsetY:    prdata = offset_y_q;
      default:                prdata = '0;
    endcase
  end

  // Sequencer: walks each track through its divisions and multiplies and
  // hands every finished piece to the output register.
  tts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .op_o        (op)
  );

  // Datapath: track and piece registers, shared multiplier and divider.
  tts_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .in_data_i     (in_data_i),
    .max_time_i    (max_time_q),
    .slice_count_i (slice_count_q),
    .offset_y_i    (offset_y_q),
    .status_o      (status),
    .out_data_o    (out_data_o)
  );

endmodule
